FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/nrs_pkg.sv
// ---------------------------------------------------------------------------
// nrs_pkg
// widths, codes, control types and helpers of the nearest request scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package nrs_pkg;

  localparam int BOARD_DEPTH    = 8;
  localparam int MAX_REQUESTERS = 16;

  localparam int IDX_W  = (BOARD_DEPTH > 1) ? $clog2(BOARD_DEPTH) : 1;
  localparam int OCC_W  = $clog2(BOARD_DEPTH + 1);
  localparam int LIVE_W = $clog2(MAX_REQUESTERS + 1);

  localparam int CAP_W  = 4;
  localparam int RCNT_W = 5;
  localparam int REQ_W  = 4;
  localparam int NUM_W  = 10;
  localparam int LAST_W = NUM_W + 1;
  localparam int DIFF_W = NUM_W + 2;
  localparam int DIST_W = NUM_W + 1;

  localparam int CMP_A  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int CMP_B  = (LIVE_W > RCNT_W) ? LIVE_W : RCNT_W;
  localparam int CMP_W  = ((CMP_A > CMP_B) ? CMP_A : CMP_B) + 1;

  localparam int CFG_DATA_W = RCNT_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REQ_COUNT = 1'd1;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 4'd8;
  localparam logic [RCNT_W-1:0] RCNT_RESET = 5'd1;

  localparam logic OP_POST   = 1'b0;
  localparam logic OP_RETIRE = 1'b1;

  localparam logic STATUS_SERVED   = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_EMIT
  } nrs_state_t;

  typedef struct packed {
    logic in_ready;
    logic take;
    logic apply;
    logic scan_clear;
    logic scan_step;
    logic emit;
  } nrs_cmd_t;

  typedef struct packed {
    logic reject;
    logic serve;
    logic scan_last;
    logic out_free;
  } nrs_sts_t;

  // capacity above the board depth acts as the board depth
  function automatic logic [OCC_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] cap_x;
    cap_x = CMP_W'(cap);
    if (cap_x > CMP_W'(BOARD_DEPTH)) begin
      return OCC_W'(BOARD_DEPTH);
    end
    return OCC_W'(cap);
  endfunction

  // live count load, held at the requester limit
  function automatic logic [LIVE_W-1:0] live_load(input logic [RCNT_W-1:0] v);
    logic [CMP_W-1:0] v_x;
    v_x = CMP_W'(v);
    if (v_x > CMP_W'(MAX_REQUESTERS)) begin
      return LIVE_W'(MAX_REQUESTERS);
    end
    return LIVE_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: design/nrs_in_if.sv
// ---------------------------------------------------------------------------
// nrs_in_if
// request channel: post or retire items with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface nrs_in_if import nrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [REQ_W-1:0] requester;
  logic [NUM_W-1:0] request_number;

  modport source (output valid, output op, output requester, output request_number,
                  input ready);
  modport sink   (input valid, input op, input requester, input request_number,
                  output ready);
endinterface

`default_nettype wire

FILE: design/nrs_out_if.sv
// ---------------------------------------------------------------------------
// nrs_out_if
// result channel: served entries and reject notices with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface nrs_out_if import nrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [REQ_W-1:0] served_requester;
  logic [NUM_W-1:0] served_number;

  modport source (output valid, output status, output served_requester,
                  output served_number, input ready);
  modport sink   (input valid, input status, input served_requester,
                  input served_number, output ready);
endinterface

`default_nettype wire

FILE: design/nrs_ctrl.sv
// ---------------------------------------------------------------------------
// nrs_ctrl
// sequencer: accept, apply, entry scan and result hand-off
// ---------------------------------------------------------------------------
`default_nettype none

module nrs_ctrl import nrs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire nrs_sts_t sts,
  output nrs_cmd_t      cmd
);

  nrs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.reject) begin
          state_nxt = ST_EMIT;
        end else if (sts.serve) begin
          cmd.scan_clear = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/nrs_dp.sv
// ---------------------------------------------------------------------------
// nrs_dp
// request board, configuration registers, nearest-entry search, result register
// ---------------------------------------------------------------------------
`default_nettype none

module nrs_dp import nrs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_op,
  input  wire logic [REQ_W-1:0]      in_requester,
  input  wire logic [NUM_W-1:0]      in_request_number,
  input  wire logic                  out_ready,
  input  wire nrs_cmd_t              cmd,
  output nrs_sts_t                   sts,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [REQ_W-1:0]           out_served_requester,
  output logic [NUM_W-1:0]           out_served_number
);

  // configuration and counters
  logic [CAP_W-1:0]  cap_r;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [LAST_W-1:0] last_r;

  // board
  logic              valid_r [BOARD_DEPTH];
  logic [REQ_W-1:0]  req_r   [BOARD_DEPTH];
  logic [NUM_W-1:0]  num_r   [BOARD_DEPTH];
  logic [IDX_W-1:0]  age_r   [BOARD_DEPTH];

  // latched item
  logic              item_op_r;
  logic [REQ_W-1:0]  item_req_r;
  logic [NUM_W-1:0]  item_num_r;
  logic              reject_r;

  // search
  logic [IDX_W-1:0]  scan_idx_r;
  logic              best_found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_age_r;
  logic [REQ_W-1:0]  best_req_r;
  logic [NUM_W-1:0]  best_num_r;

  // result register
  logic              out_valid_r;
  logic              out_status_r;
  logic [REQ_W-1:0]  out_req_r;
  logic [NUM_W-1:0]  out_num_r;

  logic [OCC_W-1:0]  eff_cap;
  logic              post_ok;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              cand_take;
  logic [DIFF_W-1:0] diff;
  logic [DIST_W-1:0] cand_dist;

  assign eff_cap = eff_capacity(cap_r);
  assign post_ok = (item_op_r == OP_POST) && (occ_r < eff_cap);

  // first free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < BOARD_DEPTH; i++) begin
      if (!valid_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    occ_nxt  = post_ok ? occ_r + OCC_W'(1) : occ_r;
    live_nxt = live_r;
    if (item_op_r == OP_RETIRE && live_r != '0) begin
      live_nxt = live_r - LIVE_W'(1);
    end
  end

  always_comb begin
    sts.reject    = (item_op_r == OP_POST) && !post_ok;
    sts.serve     = (occ_nxt != '0) &&
                    (occ_nxt == eff_cap || CMP_W'(occ_nxt) == CMP_W'(live_nxt));
    sts.scan_last = (scan_idx_r == IDX_W'(BOARD_DEPTH - 1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // distance from the last served number
  always_comb begin
    diff      = DIFF_W'({1'b0, num_r[scan_idx_r]}) - {last_r[LAST_W-1], last_r};
    cand_dist = diff[DIFF_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    cand_take = valid_r[scan_idx_r] &&
                (!best_found_r || cand_dist < best_dist_r ||
                 (cand_dist == best_dist_r && age_r[scan_idx_r] < best_age_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_op_r  <= in_op;
      item_req_r <= in_requester;
      item_num_r <= in_request_number;
    end
    if (cmd.apply) begin
      reject_r <= sts.reject;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      live_r <= live_load(RCNT_RESET);
      occ_r  <= '0;
      last_r <= '1;
      for (int i = 0; i < BOARD_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_CAPACITY:  cap_r  <= cfg_wdata[CAP_W-1:0];
          CFG_IDX_REQ_COUNT: live_r <= live_load(cfg_wdata[RCNT_W-1:0]);
          default: begin
          end
        endcase
      end
      if (cmd.apply) begin
        occ_r  <= occ_nxt;
        live_r <= live_nxt;
        if (post_ok && free_found) begin
          for (int i = 0; i < BOARD_DEPTH; i++) begin
            if (valid_r[i]) begin
              age_r[i] <= age_r[i] + IDX_W'(1);
            end
          end
          valid_r[free_idx] <= 1'b1;
          req_r[free_idx]   <= item_req_r;
          num_r[free_idx]   <= item_num_r;
          age_r[free_idx]   <= '0;
        end
      end
      if (cmd.emit && !reject_r) begin
        // remove the served entry and close the age gap
        for (int i = 0; i < BOARD_DEPTH; i++) begin
          if (valid_r[i] && age_r[i] > best_age_r) begin
            age_r[i] <= age_r[i] - IDX_W'(1);
          end
        end
        valid_r[best_idx_r] <= 1'b0;
        occ_r               <= occ_r - OCC_W'(1);
        last_r              <= LAST_W'(best_num_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= sts.scan_last ? '0 : scan_idx_r + IDX_W'(1);
      if (cand_take) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && cand_take) begin
      best_idx_r  <= scan_idx_r;
      best_dist_r <= cand_dist;
      best_age_r  <= age_r[scan_idx_r];
      best_req_r  <= req_r[scan_idx_r];
      best_num_r  <= num_r[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (reject_r) begin
        out_status_r <= STATUS_REJECTED;
        out_req_r    <= '0;
        out_num_r    <= '0;
      end else begin
        out_status_r <= STATUS_SERVED;
        out_req_r    <= best_req_r;
        out_num_r    <= best_num_r;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_served_requester = out_req_r;
  assign out_served_number    = out_num_r;

endmodule

`default_nettype wire

FILE: design/nearest_request_scheduler_core.sv
// ---------------------------------------------------------------------------
// nearest_request_scheduler_core
// request board with nearest-number-first service
// ---------------------------------------------------------------------------
// One item at a time. A retire, or a post that does not trigger service, passes
// through the apply state back to idle; a rejected post goes from apply to the
// emit state; a post or retire that triggers service also runs the search,
// which visits one board entry per cycle, before the emit state.
// The result sits in an output register, so the next item is taken while a
// result waits, unless that item has a result of its own to hand off.
`default_nettype none
`include "assert_macros.svh"

module nearest_request_scheduler_core import nrs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  nrs_in_if.sink                     in_ch,
  nrs_out_if.source                  out_ch
);

  nrs_cmd_t cmd;
  nrs_sts_t sts;

  assign in_ch.ready = cmd.in_ready;

  nrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  nrs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_op                (in_ch.op),
    .in_requester         (in_ch.requester),
    .in_request_number    (in_ch.request_number),
    .out_ready            (out_ch.ready),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_ch.valid),
    .out_status           (out_ch.status),
    .out_served_requester (out_ch.served_requester),
    .out_served_number    (out_ch.served_number)
  );

  // one item in flight
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // a result is only loaded into a free output register
  `ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
  // the search stops after the last entry
  `ASSERT_NEXT(a_scan_ends, clk, rst_n, cmd.scan_step && sts.scan_last, !cmd.scan_step)
  // take only in the idle state
  `ASSERT_IMPLIES(a_take_idle, clk, rst_n, cmd.take, cmd.in_ready && in_ch.valid)

endmodule

`default_nettype wire
